// ----- rtl/zrocf_pkg.sv -----
package zrocf_pkg;

    localparam int MAX_SIZE = 16;
    localparam int ROW_W    = 16;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CNT_W    = IDX_W + 1;

    localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(MAX_SIZE);

    typedef logic [ROW_W-1:0] row_t;

    typedef struct packed {
        logic             start;
        logic             ack;
        logic [CNT_W-1:0] size;
    } srch_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             found;
        logic [IDX_W-1:0] k_index;
    } srch_rsp_t;

    function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] n;
        n = size;
        if (size == '0) begin
            n = CNT_W'(1);
        end else if (size > CNT_W'(MAX_SIZE)) begin
            n = CNT_W'(MAX_SIZE);
        end
        return n;
    endfunction

    function automatic row_t row_mask(input logic [CNT_W-1:0] n);
        row_t ones;
        ones = '1;
        return ~(ones << n);
    endfunction

endpackage

// ----- rtl/zrocf_ram.sv -----
module zrocf_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/zrocf_search.sv -----
module zrocf_search (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  zrocf_pkg::srch_req_t            req,
    output zrocf_pkg::srch_rsp_t            rsp,
    output logic [zrocf_pkg::IDX_W-1:0]     rd_addr,
    input  zrocf_pkg::row_t                 rd_data
);
    import zrocf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WTOP,
        S_WDOWN,
        S_WLEFT,
        S_CROW,
        S_CCOL,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] walk_row_reg, walk_row_next;
    logic [CNT_W-1:0] walk_col_reg, walk_col_next;
    logic [IDX_W-1:0] candidate_reg, candidate_next;
    logic [IDX_W-1:0] t_reg, t_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             cell_bit;
    logic             col_bit;
    row_t             others;

    assign cell_bit = rd_data[walk_col_reg[IDX_W-1:0]];
    assign col_bit  = rd_data[candidate_reg];
    assign others   = rd_data & ~(row_t'(1) << candidate_reg);

    always_comb begin
        state_next     = state_reg;
        walk_row_next  = walk_row_reg;
        walk_col_next  = walk_col_reg;
        candidate_next = candidate_reg;
        t_next         = t_reg;
        found_next     = found_reg;
        k_next         = k_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (req.start) begin
                    walk_row_next = '0;
                    walk_col_next = req.size - CNT_W'(1);
                    state_next    = S_PREP;
                end
            end
            S_PREP: begin
                state_next = S_WTOP;
            end
            S_WTOP: begin
                if (walk_row_reg >= req.size || walk_col_reg[CNT_W-1]) begin
                    found_next = 1'b0;
                    k_next     = '0;
                    state_next = S_DONE;
                end else if (cell_bit) begin
                    walk_row_next = walk_row_reg + CNT_W'(1);
                    state_next    = S_WDOWN;
                end else begin
                    walk_col_next = walk_col_reg - CNT_W'(1);
                    state_next    = S_WLEFT;
                end
            end
            S_WDOWN: begin
                if (walk_row_reg == req.size) begin
                    candidate_next = walk_col_reg[IDX_W-1:0];
                    state_next     = S_CROW;
                end else if (cell_bit) begin
                    walk_row_next = walk_row_reg + CNT_W'(1);
                end else begin
                    walk_col_next = walk_col_reg - CNT_W'(1);
                    state_next    = S_WTOP;
                end
            end
            S_WLEFT: begin
                if (walk_col_reg[CNT_W-1]) begin
                    candidate_next = walk_row_reg[IDX_W-1:0];
                    state_next     = S_CROW;
                end else if (!cell_bit) begin
                    walk_col_next = walk_col_reg - CNT_W'(1);
                end else begin
                    walk_row_next = walk_row_reg + CNT_W'(1);
                    state_next    = S_WTOP;
                end
            end
            S_CROW: begin
                if (others != '0) begin
                    found_next = 1'b0;
                    k_next     = '0;
                    state_next = S_DONE;
                end else begin
                    t_next     = '0;
                    state_next = S_CCOL;
                end
            end
            S_CCOL: begin
                if (t_reg != candidate_reg && !col_bit) begin
                    found_next = 1'b0;
                    k_next     = '0;
                    state_next = S_DONE;
                end else if ({1'b0, t_reg} + CNT_W'(1) == req.size) begin
                    found_next = 1'b1;
                    k_next     = candidate_reg;
                    state_next = S_DONE;
                end else begin
                    t_next = t_reg + IDX_W'(1);
                end
            end
            S_DONE: begin
                if (req.ack) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The read address follows the next state so that the data seen in each
    // state always belongs to that state's row.
    always_comb begin
        unique case (state_next)
            S_CROW:  rd_addr = candidate_next;
            S_CCOL:  rd_addr = t_next;
            default: rd_addr = walk_row_next[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            walk_row_reg  <= '0;
            walk_col_reg  <= '0;
            candidate_reg <= '0;
            t_reg         <= '0;
            found_reg     <= 1'b0;
            k_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            walk_row_reg  <= walk_row_next;
            walk_col_reg  <= walk_col_next;
            candidate_reg <= candidate_next;
            t_reg         <= t_next;
            found_reg     <= found_next;
            k_reg         <= k_next;
        end
    end

    assign rsp.busy    = (state_reg != S_IDLE);
    assign rsp.done    = (state_reg == S_DONE);
    assign rsp.found   = found_reg;
    assign rsp.k_index = k_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && req.start) |=> (state_reg == S_PREP && walk_row_reg == '0))
        else $error("search did not begin at the top row");
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.done && !rsp.found) |-> (rsp.k_index == '0))
        else $error("index not cleared on a failed search");
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.done && !req.ack) |=> (rsp.done && $stable(rsp.found) && $stable(rsp.k_index)))
        else $error("result changed before it was taken");
`endif

endmodule

// ----- rtl/zero_row_one_column_finder.sv -----
// Zero-row, one-column finder.
// Rows of an n-by-n boolean matrix enter on the s_ channel, one row per item,
// row 0 first; bit j of s_row_bits is column j and bits at or above n are
// dropped. A row is taken while s_valid and s_ready are both high. Rows other
// than the last give no result. The last row starts a search that holds
// s_ready low while it primes the row memory, walks the staircase, tests the
// candidate's row and, if that passes, its column, and hands the result over,
// all through the single read port of the row memory; a walk that finds no
// candidate goes straight to the hand-over. One result item then appears on
// the m_ channel: m_found and m_k_index, with m_k_index zero when nothing is
// found.
// The result sits in an output register, so rows of the next matrix are taken
// while it waits; if the receiver still stalls when the next search ends, that
// search waits and s_ready stays low until the register frees.
// A write on cfg_wr_en sets n (zero acts as one, above 16 acts as 16) and
// restarts loading at row 0; write it only while the block is idle.
// Reset sets n to 16, empties the output register and restarts loading.
module zero_row_one_column_finder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [zrocf_pkg::CNT_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [zrocf_pkg::ROW_W-1:0]   s_row_bits,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_found,
    output logic [zrocf_pkg::IDX_W-1:0]   m_k_index
);
    import zrocf_pkg::*;

    logic [CNT_W-1:0] size_reg;
    logic [CNT_W-1:0] rows_loaded_reg, rows_loaded_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [IDX_W-1:0] m_k_reg, m_k_next;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] row_idx;
    logic             in_fire;
    logic             last_row;
    logic             out_load;
    srch_req_t        req;
    srch_rsp_t        rsp;
    logic [IDX_W-1:0] rd_addr;
    row_t             rd_data;

    assign n_eff    = eff_size(size_reg);
    assign row_idx  = (rows_loaded_reg >= n_eff) ? '0 : rows_loaded_reg;
    assign s_ready  = !rsp.busy;
    assign in_fire  = s_valid && s_ready;
    assign last_row = (row_idx + CNT_W'(1) == n_eff);
    assign out_load = rsp.done && (!m_valid_reg || m_ready);

    assign req.start = in_fire && last_row;
    assign req.ack   = out_load;
    assign req.size  = n_eff;

    zrocf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SIZE)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (in_fire),
        .wr_addr (row_idx[IDX_W-1:0]),
        .wr_data (s_row_bits & row_mask(n_eff)),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    zrocf_search u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        rows_loaded_next = rows_loaded_reg;
        m_valid_next     = m_valid_reg;
        m_found_next     = m_found_reg;
        m_k_next         = m_k_reg;
        if (in_fire) begin
            rows_loaded_next = last_row ? '0 : row_idx + CNT_W'(1);
        end
        if (cfg_wr_en) begin
            rows_loaded_next = '0;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            m_found_next = rsp.found;
            m_k_next     = rsp.k_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg        <= SIZE_RESET;
            rows_loaded_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            rows_loaded_reg <= rows_loaded_next;
            m_valid_reg     <= m_valid_next;
        end
        m_found_reg <= m_found_next;
        m_k_reg     <= m_k_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_found   = m_found_reg;
    assign m_k_index = m_k_reg;

`ifndef SYNTHESIS
    a_rows_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_loaded_reg < n_eff)
        else $error("row count reached the matrix size");
    a_start_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> !s_ready)
        else $error("input still ready after the last row");
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten while full");
    a_no_item_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.done && m_valid_reg && !m_ready) |=> rsp.done)
        else $error("search result dropped while the receiver stalled");
`endif

endmodule

// ----- tb/sv/zero_row_one_column_finder_tb.sv -----
`timescale 1ns / 100ps

module zero_row_one_column_finder_tb;
    import zrocf_pkg::*;

    localparam int SETTLE_CYCLES = 4 * MAX_SIZE + 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ROWS    = 384;
    localparam int SHOWN_ERRORS  = 10;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] k_index;
    } verdict_t;

    typedef struct packed {
        logic             is_size;
        logic [CNT_W-1:0] size;
        row_t             bits;
        logic             typed;
        verdict_t         want;
    } plan_step_t;

    logic             aclk;
    logic             aresetn     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0] cfg_wr_data = '0;
    logic             s_valid     = 1'b0;
    row_t             s_row_bits  = '0;
    logic             m_ready     = 1'b0;
    logic             s_ready;
    logic             m_valid;
    logic             m_found;
    logic [IDX_W-1:0] m_k_index;

    row_t             row_store [MAX_SIZE];
    int               rows_held;
    logic [CNT_W-1:0] size_reg = SIZE_RESET;
    verdict_t         pending_verdicts [$];
    plan_step_t       plan [$];

    int send_idle_pct;
    int recv_idle_pct;
    int rows_sent;
    int verdicts_seen;
    int found_seen;
    int sizes_written;
    int mismatch_count;
    int stall_cycles;

    zero_row_one_column_finder dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_row_bits (s_row_bits),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_found    (m_found),
        .m_k_index  (m_k_index)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    function automatic int clamp_size(input logic [CNT_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > MAX_SIZE) begin
            return MAX_SIZE;
        end
        return int'(v);
    endfunction

    function automatic row_t low_mask(input int n);
        if (n >= ROW_W) begin
            return '1;
        end
        return row_t'((1 << n) - 1);
    endfunction

    function automatic logic cell_at(input int r, input int c);
        if (r < 0 || r >= MAX_SIZE || c < 0 || c >= ROW_W) begin
            return 1'b0;
        end
        return row_store[r][c];
    endfunction

    // Staircase walk from the top-right corner, then a full check of the pick.
    function automatic verdict_t judge_matrix(input int n);
        int r;
        int c;
        int pick;
        int t;
        logic ok;
        verdict_t v;
        r = 0;
        c = n - 1;
        pick = -1;
        while (pick < 0 && r >= 0 && r < n && c >= 0 && c < n) begin
            if (cell_at(r, c)) begin
                while (r < n && cell_at(r, c)) r++;
                if (r == n) begin
                    pick = c;
                end else begin
                    c--;
                end
            end else begin
                while (c >= 0 && !cell_at(r, c)) c--;
                if (c < 0) begin
                    pick = r;
                end else begin
                    r++;
                end
            end
        end
        v = '0;
        if (pick >= 0) begin
            ok = 1'b1;
            for (t = 0; t < n; t++) begin
                if (t != pick && cell_at(pick, t)) ok = 1'b0;
                if (t != pick && !cell_at(t, pick)) ok = 1'b0;
            end
            if (ok) begin
                v.found   = 1'b1;
                v.k_index = IDX_W'(pick);
            end
        end
        return v;
    endfunction

    function automatic logic absorb_row(input row_t bits, output verdict_t v);
        int n;
        n = clamp_size(size_reg);
        v = '0;
        if (rows_held >= n) rows_held = 0;
        row_store[rows_held] = bits & low_mask(n);
        if (rows_held + 1 < n) begin
            rows_held++;
            return 1'b0;
        end
        rows_held = 0;
        v = judge_matrix(n);
        return 1'b1;
    endfunction

    function automatic plan_step_t size_step(input logic [CNT_W-1:0] v);
        plan_step_t s;
        s = '0;
        s.is_size = 1'b1;
        s.size = v;
        return s;
    endfunction

    function automatic plan_step_t row_step(input row_t b);
        plan_step_t s;
        s = '0;
        s.bits = b;
        return s;
    endfunction

    function automatic plan_step_t checked_step(input row_t b, input logic f,
                                                input int k);
        plan_step_t s;
        s = row_step(b);
        s.typed = 1'b1;
        s.want.found = f;
        s.want.k_index = IDX_W'(k);
        return s;
    endfunction

    task automatic send_row(input row_t bits, input logic typed, input verdict_t typed_v);
        verdict_t v;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_row_bits <= bits;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        rows_sent++;
        if (absorb_row(bits, v)) begin
            pending_verdicts.push_back(typed ? typed_v : v);
        end
    endtask

    task automatic write_size(input logic [CNT_W-1:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        size_reg  = v;
        rows_held = 0;
        sizes_written++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Most matrices carry a planted answer, some of them then spoiled by one
    // flipped entry; a few are cut short so the next rows start mid-matrix.
    task automatic send_matrix(input int n);
        row_t rows [MAX_SIZE];
        row_t low;
        int r;
        int c;
        int k;
        int stop_at;
        low = low_mask(n);
        for (r = 0; r < n; r++) begin
            case ($urandom_range(2))
                0: rows[r] = row_t'($urandom);
                1: rows[r] = row_t'($urandom & $urandom & $urandom);
                default: rows[r] = row_t'($urandom | $urandom);
            endcase
        end
        if ($urandom_range(99) < 65) begin
            k = $urandom_range(n - 1);
            for (r = 0; r < n; r++) begin
                if (r == k) begin
                    rows[r] = (rows[r] & ~low) | (row_t'($urandom_range(1)) << k);
                end else begin
                    rows[r] = rows[r] | (row_t'(1) << k);
                end
            end
            if ($urandom_range(3) == 0) begin
                r = $urandom_range(n - 1);
                c = $urandom_range(n - 1);
                rows[r][c] = ~rows[r][c];
            end
        end
        stop_at = ($urandom_range(99) < 8) ? int'($urandom_range(n - 1)) : n;
        for (r = 0; r < stop_at; r++) begin
            send_row(rows[r], 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int sidle, input int ridle);
        int first_row;
        int sel;
        int n;
        logic [CNT_W-1:0] v;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        first_row = rows_sent;
        while (rows_sent - first_row < PHASE_ROWS) begin
            sel = $urandom_range(99);
            if (sel < 5) begin
                v = '0;
            end else if (sel < 10) begin
                v = CNT_W'(1);
            end else if (sel < 16) begin
                v = CNT_W'($urandom_range(31, MAX_SIZE + 1));
            end else if (sel < 24) begin
                v = CNT_W'(MAX_SIZE);
            end else if (sel < 70) begin
                v = CNT_W'($urandom_range(5, 2));
            end else begin
                v = CNT_W'($urandom_range(MAX_SIZE - 1, 6));
            end
            write_size(v);
            n = clamp_size(v);
            repeat ((n > 8) ? $urandom_range(2, 1) : $urandom_range(6, 2)) begin
                send_matrix(n);
            end
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : verdict_check
        verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            verdicts_seen++;
            if (m_found) found_seen++;
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOWN_ERRORS) begin
                    $display("unexpected verdict at %0t: found=%0b k=%0d",
                             $time, m_found, m_k_index);
                end
            end else begin
                want = pending_verdicts.pop_front();
                if (m_found !== want.found || m_k_index !== want.k_index) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS) begin
                        $display("verdict mismatch at %0t: expected found=%0b k=%0d, got found=%0b k=%0d",
                                 $time, want.found, want.k_index, m_found, m_k_index);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d verdicts outstanding",
                     stall_cycles, pending_verdicts.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int i;
        for (i = 0; i < MAX_SIZE - 1; i++) begin
            plan.push_back(row_step((i % 2 == 0) ? 16'hFFFF : 16'h0020));
        end
        plan.push_back(checked_step(16'h0020, 1'b1, 5));
        plan.push_back(size_step('0));
        plan.push_back(checked_step(16'hFFFF, 1'b1, 0));
        plan.push_back(size_step(CNT_W'(2)));
        plan.push_back(row_step(16'h0000));
        plan.push_back(checked_step(16'h0001, 1'b1, 0));
        plan.push_back(row_step(16'hFFFC));
        plan.push_back(checked_step(16'hFFFC, 1'b0, 0));
        plan.push_back(size_step(CNT_W'(3)));
        plan.push_back(row_step(16'h0007));
        plan.push_back(size_step(CNT_W'(3)));
        plan.push_back(row_step(16'h0002));
        plan.push_back(row_step(16'h0000));
        plan.push_back(checked_step(16'h0003, 1'b1, 1));

        send_idle_pct = 35;
        recv_idle_pct = 78;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[j]) begin
            if (plan[j].is_size) begin
                write_size(plan[j].size);
            end else begin
                send_row(plan[j].bits, plan[j].typed, plan[j].want);
            end
        end

        run_phase(35, 78);
        run_phase(78, 35);
        run_phase(0, 0);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d rows under %0d size writes and checked %0d verdicts, %0d of them found.",
                 rows_sent, sizes_written, verdicts_seen, found_seen);
        $display("Mismatches counted: %0d.", mismatch_count);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
